// ===== hdl/stbt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stbt_pkg: shared types and constants for the timer bank
// Word formats of the item and result channels, function and kind codes,
// configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package stbt_pkg;

    localparam int TICK_W         = 32;
    localparam int PER_W          = 16;
    localparam int NUM_TIMERS_DEF = 16;
    localparam int CFG_IDX_W      = 2;

    localparam logic [PER_W-1:0] RELOAD_RST  = 16'hFFFF;
    localparam logic [PER_W-1:0] PREEMPT_RST = 16'h0000;

    // function codes of an item
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_STOP  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_EXP  = 2'd1;
    localparam logic [1:0] KIND_SUMM = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RELOAD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREEMPT = 2'd1;

    typedef struct packed {
        logic [1:0]         func;
        logic [3:0]         timer_index;
        logic [30:0]        delay;
        logic signed [31:0] tag;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         kind;
        logic [3:0]         expired_index;
        logic signed [31:0] expired_tag;
        logic [31:0]        tick_count;
        logic               chain_bios;
        logic               preempt;
        logic               last;
    } t_out_word;

endpackage
`default_nettype wire

// ===== hdl/software_timer_bank_tick_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// software_timer_bank_tick_top: countdown timer bank
// Start, stop and tick items on a bank of tagged countdown timers; a tick
// walks the bank, reports expiries and closes with a summary word.
// ----------------------------------------------------------------------------
// channel  direction  handshake                  payload
// in       input      i_in_valid / o_in_ready    i_in_word  (t_in_word)
// out      output     o_out_valid / i_out_ready  o_out_word (t_out_word)
// cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// a tick walks the timer memory (one entry per cycle while the output does not
// stall) and meanwhile runs the remainder unit for the preempt test (two bits
// per cycle); the summary word waits for both.
// an output stall holds the walk on the entry whose expiry word waits.
// synchronous active-low reset; timer memory contents are not cleared,
// entries are read only behind their active flag.
// ----------------------------------------------------------------------------
module software_timer_bank_tick_top #(
    parameter int NUM_TIMERS = stbt_pkg::NUM_TIMERS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  stbt_pkg::t_in_word             i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output stbt_pkg::t_out_word            o_out_word,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [stbt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [stbt_pkg::PER_W-1:0]     i_cfg_data
);
    import stbt_pkg::*;

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

    typedef struct packed {
        logic [TICK_W-1:0] remaining;
        logic [TICK_W-1:0] tag;
    } t_entry;

    typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_SUMM} t_state;

    t_state            r_state;
    logic              r_out_valid;
    t_out_word         r_out_word;
    logic              r_active [NUM_TIMERS];
    logic [IDX_W-1:0]  r_idx;
    logic [TICK_W-1:0] r_tick;
    logic [PER_W-1:0]  r_phase;
    logic              r_chain;
    logic [PER_W-1:0]  r_reload;
    logic [PER_W-1:0]  r_preempt_per;

    t_entry            r_mem [NUM_TIMERS];
    t_entry            r_rdata;

    logic              slot_free;
    logic              in_fire;
    logic              in_hit;
    logic [IDX_W-1:0]  in_addr;
    logic              tick_go;
    logic              set_go;
    logic              clr_go;
    logic [TICK_W-1:0] n_tick;
    logic [PER_W:0]    n_phase;
    logic              cur_active;
    logic [TICK_W-1:0] rem_dec;
    logic              expired;
    logic              emit;
    logic              advance;
    logic              out_load;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    t_entry            wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              div_done;
    logic [PER_W-1:0]  div_rem;
    logic              preempt_due;

    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && slot_free;
    assign in_fire    = i_in_valid && o_in_ready;
    assign in_hit     = int'(i_in_word.timer_index) < NUM_TIMERS;
    assign in_addr    = IDX_W'(i_in_word.timer_index);
    assign tick_go    = in_fire && (i_in_word.func == FUNC_TICK);
    assign set_go     = in_fire && (i_in_word.func == FUNC_START) && in_hit;
    assign clr_go     = in_fire && (i_in_word.func == FUNC_STOP) && in_hit;

    assign n_tick  = r_tick + 1'b1;
    assign n_phase = {1'b0, r_phase} + {1'b0, r_reload} + (PER_W + 1)'(1);

    // walk: read data of entry r_idx is in r_rdata
    assign cur_active = r_active[r_idx];
    assign rem_dec    = r_rdata.remaining - 1'b1;
    assign expired    = (rem_dec == '0) || rem_dec[TICK_W-1];
    assign emit       = (r_state == ST_WALK) && cur_active && expired;
    assign advance    = (r_state == ST_WALK) && (!emit || slot_free);

    // a new result word enters the output register this cycle
    assign out_load = set_go || clr_go || (emit && slot_free)
                      || ((r_state == ST_SUMM) && div_done && slot_free);

    always_comb begin
        wr_en             = 1'b0;
        wr_addr           = in_addr;
        wr_data.remaining = {1'b0, i_in_word.delay};
        wr_data.tag       = i_in_word.tag;
        if (set_go) begin
            wr_en = 1'b1;
        end else if (advance && cur_active) begin
            wr_en             = 1'b1;
            wr_addr           = r_idx;
            wr_data.remaining = rem_dec;
            wr_data.tag       = r_rdata.tag;
        end
    end

    // prefetch the next entry while the current one is written back
    assign rd_en   = tick_go || (advance && (r_idx != LAST_IDX));
    assign rd_addr = tick_go ? '0 : IDX_W'(r_idx + 1'b1);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    stbt_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (tick_go),
        .i_dividend (n_tick),
        .i_divisor  (r_preempt_per),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    assign preempt_due = (r_preempt_per != '0) && (div_rem == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload      <= RELOAD_RST;
            r_preempt_per <= PREEMPT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RELOAD:  r_reload      <= i_cfg_data;
                CFG_PREEMPT: r_preempt_per <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_active    <= '{default: 1'b0};
            r_idx       <= '0;
            r_tick      <= '0;
            r_phase     <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (tick_go) begin
                        r_tick  <= n_tick;
                        r_phase <= n_phase[PER_W-1:0];
                        r_chain <= n_phase[PER_W];
                        r_idx   <= '0;
                        r_state <= ST_WALK;
                    end else if (set_go || clr_go) begin
                        r_active[in_addr] <= set_go;
                        r_out_word        <= '{kind: KIND_ACK,
                                               expired_index: i_in_word.timer_index,
                                               expired_tag: '0,
                                               tick_count: r_tick,
                                               chain_bios: 1'b0,
                                               preempt: 1'b0,
                                               last: 1'b1};
                    end
                end
                ST_WALK: begin
                    if (advance) begin
                        if (emit) begin
                            r_active[r_idx] <= 1'b0;
                            r_out_word      <= '{kind: KIND_EXP,
                                                 expired_index: 4'(r_idx),
                                                 expired_tag: r_rdata.tag,
                                                 tick_count: r_tick,
                                                 chain_bios: 1'b0,
                                                 preempt: 1'b0,
                                                 last: 1'b0};
                        end
                        if (r_idx == LAST_IDX) begin
                            r_state <= ST_SUMM;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                ST_SUMM: begin
                    if (div_done && slot_free) begin
                        r_out_word  <= '{kind: KIND_SUMM,
                                         expired_index: '0,
                                         expired_tag: '0,
                                         tick_count: r_tick,
                                         chain_bios: r_chain,
                                         preempt: preempt_due,
                                         last: 1'b1};
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
`default_nettype wire

// ===== hdl/stbt_mod.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stbt_mod: serial remainder unit
// Computes dividend mod divisor for a 32-bit dividend and 16-bit divisor,
// two quotient bits per cycle, result valid once o_done is high.
// ----------------------------------------------------------------------------
module stbt_mod (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [stbt_pkg::TICK_W-1:0] i_dividend,
    input  logic [stbt_pkg::PER_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [stbt_pkg::PER_W-1:0]  o_rem
);
    import stbt_pkg::*;

    localparam int STEPS = TICK_W / 2;
    localparam int CNT_W = $clog2(STEPS);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [TICK_W-1:0] r_dvd;
    logic [PER_W-1:0] r_div;
    logic [PER_W-1:0] r_rem;
    logic [PER_W-1:0] n_rem;
    logic [PER_W:0]   t1;
    logic [PER_W:0]   t2;

    // two restoring steps; remainder stays below a nonzero divisor
    always_comb begin
        t1 = {r_rem, r_dvd[TICK_W-1]};
        if (t1 >= {1'b0, r_div}) begin
            t1 = t1 - {1'b0, r_div};
        end
        t2 = {t1[PER_W-1:0], r_dvd[TICK_W-2]};
        if (t2 >= {1'b0, r_div}) begin
            t2 = t2 - {1'b0, r_div};
        end
        n_rem = t2[PER_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_dvd  <= i_dividend;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= r_dvd << 2;
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

// ===== hdl/stbt_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stbt_chk: port-level checks for the timer bank
// Watches the top-level channels and flags handshake and sequencing faults.
// ----------------------------------------------------------------------------
module stbt_chk #(
    parameter int NUM_TIMERS = stbt_pkg::NUM_TIMERS_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input stbt_pkg::t_in_word             i_in_word,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input stbt_pkg::t_out_word            o_out_word,
    input logic                           i_cfg_valid,
    input logic                           o_cfg_ready,
    input logic [stbt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic [stbt_pkg::PER_W-1:0]     i_cfg_data
);
    import stbt_pkg::*;

    logic in_fire;
    logic cmd_hit;

    assign in_fire = i_in_valid && o_in_ready;
    assign cmd_hit = ((i_in_word.func == FUNC_START) || (i_in_word.func == FUNC_STOP))
                     && (int'(i_in_word.timer_index) < NUM_TIMERS);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_word)))
        else $error("result word changed while stalled");

    // start or stop in range is acknowledged on the next cycle
    a_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && cmd_hit) |=>
        (o_out_valid && (o_out_word.kind == KIND_ACK) && o_out_word.last
         && (o_out_word.expired_index == $past(i_in_word.timer_index))))
        else $error("missing acknowledge for start or stop");

    // a tick busies the block
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_in_word.func == FUNC_TICK)) |=> !o_in_ready)
        else $error("item accepted during tick walk");

    // only expiry words leave last low
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.last == (o_out_word.kind != KIND_EXP)))
        else $error("last flag does not match result kind");

    // configuration port never stalls
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write stalled");

endmodule

bind software_timer_bank_tick_top stbt_chk #(.NUM_TIMERS(NUM_TIMERS)) u_stbt_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_cfg_index (i_cfg_index),
    .i_cfg_data  (i_cfg_data)
);
`default_nettype wire

// ===== bench/tb_software_timer_bank_tick_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_software_timer_bank_tick_top: self-checking bench for the timer bank
// Sends start, stop and tick words with random gaps on both channels, keeps a
// shadow copy of the bank to work out every acknowledge, expiry and summary
// word, and checks each result word field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb_software_timer_bank_tick_top;
    import stbt_pkg::*;

    localparam int         NUM_T      = NUM_TIMERS_DEF;
    localparam logic [1:0] FUNC_NONE  = 2'd3;   // not a function, dropped by the block
    localparam int         SETTLE_CYC = 40;     // long enough for a tick walk to end

    logic                 i_clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    t_in_word             in_word = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_word            out_word;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PER_W-1:0]     cfg_data = '0;

    // shadow of the bank
    logic [31:0]      ticks_m = '0;
    logic [PER_W-1:0] phase_m = '0;
    logic [PER_W-1:0] reload_m = RELOAD_RST;
    logic [PER_W-1:0] preempt_m = PREEMPT_RST;
    logic [NUM_T-1:0] active_m = '0;
    logic [31:0]      remain_m [NUM_T];
    logic [31:0]      tag_m [NUM_T];

    t_in_word  cmd_queue [$];
    t_out_word due_words [$];
    int        errors = 0;
    int        send_idle_pct = 37;
    int        recv_idle_pct = 77;
    bit        in_taken = 1'b0;

    software_timer_bank_tick_top #(
        .NUM_TIMERS(NUM_T)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_word (out_word),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // apply one accepted word to the shadow bank and queue what it causes
    task automatic bank_step(input t_in_word w);
        logic [PER_W:0] sum;
        logic [31:0]    left;
        t_out_word      r;
        int             i;
        if (w.func == FUNC_TICK) begin
            ticks_m = ticks_m + 32'd1;
            sum = {1'b0, phase_m} + {1'b0, reload_m} + 17'd1;
            phase_m = sum[PER_W-1:0];
            for (i = 0; i < NUM_T; i++) begin
                if (active_m[i]) begin
                    left = remain_m[i] - 32'd1;
                    remain_m[i] = left;
                    // signed count: zero or below means done
                    if (left == 32'd0 || left[31]) begin
                        active_m[i] = 1'b0;
                        r = '0;
                        r.kind = KIND_EXP;
                        r.expired_index = i[3:0];
                        r.expired_tag = tag_m[i];
                        r.tick_count = ticks_m;
                        due_words.push_back(r);
                    end
                end
            end
            r = '0;
            r.kind = KIND_SUMM;
            r.tick_count = ticks_m;
            r.chain_bios = sum[PER_W];
            r.preempt = (preempt_m != '0) && (ticks_m % {16'd0, preempt_m} == 32'd0);
            r.last = 1'b1;
            due_words.push_back(r);
        end else if ((w.func == FUNC_START || w.func == FUNC_STOP)
                     && int'(w.timer_index) < NUM_T) begin
            if (w.func == FUNC_START) begin
                remain_m[w.timer_index] = {1'b0, w.delay};
                tag_m[w.timer_index] = w.tag;
                active_m[w.timer_index] = 1'b1;
            end else begin
                active_m[w.timer_index] = 1'b0;
            end
            r = '0;
            r.kind = KIND_ACK;
            r.expired_index = w.timer_index;
            r.tick_count = ticks_m;
            r.last = 1'b1;
            due_words.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    // sample at the rising edge: input acceptance and result words
    always @(posedge i_clk) begin
        t_out_word want;
        in_taken = rst_n && in_valid && in_ready;
        if (in_taken) begin
            bank_step(in_word);
        end
        if (rst_n && out_valid && out_ready) begin
            if (due_words.size() == 0) begin
                errors++;
                $display("%0t: expected no word, actual %h", $time, out_word);
            end else begin
                want = due_words.pop_front();
                check_field("kind", want.kind, out_word.kind);
                check_field("expired_index", want.expired_index, out_word.expired_index);
                check_field("expired_tag", want.expired_tag, out_word.expired_tag);
                check_field("tick_count", want.tick_count, out_word.tick_count);
                check_field("chain_bios", want.chain_bios, out_word.chain_bios);
                check_field("preempt", want.preempt, out_word.preempt);
                check_field("last", want.last, out_word.last);
            end
        end
    end

    // drive at the falling edge
    always @(negedge i_clk) begin
        if (rst_n) begin
            if (!in_valid || in_taken) begin
                if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_word <= cmd_queue.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_cmd(input logic [1:0] f, input logic [3:0] idx,
                            input logic [30:0] dly, input logic [31:0] tg);
        t_in_word w;
        w.func = f;
        w.timer_index = idx;
        w.delay = dly;
        w.tag = tg;
        cmd_queue.push_back(w);
    endtask

    // mostly short delays so timers expire; now and then arm the whole bank
    task automatic queue_random(input int count);
        int       made;
        int       pick;
        int       i;
        t_in_word w;
        made = 0;
        while (made < count) begin
            if ($urandom_range(24) == 0) begin
                for (i = 0; i < NUM_T; i++) begin
                    push_cmd(FUNC_START, i[3:0], 31'($urandom_range(2)), $urandom);
                end
                push_cmd(FUNC_TICK, 4'($urandom), 31'($urandom), $urandom);
                made += NUM_T + 1;
            end else begin
                pick = $urandom_range(99);
                w.timer_index = 4'($urandom_range(15));
                w.tag = $urandom;
                case ($urandom_range(9))
                    0: w.delay = 31'($urandom);
                    1, 2: w.delay = 31'($urandom_range(40));
                    default: w.delay = 31'($urandom_range(8));
                endcase
                if (pick < 45) begin
                    w.func = FUNC_TICK;
                end else if (pick < 80) begin
                    w.func = FUNC_START;
                end else if (pick < 95) begin
                    w.func = FUNC_STOP;
                end else begin
                    w.func = FUNC_NONE;
                end
                cmd_queue.push_back(w);
                if (w.func != FUNC_NONE) begin
                    made++;
                end
            end
        end
    endtask

    // every word sent and answered, then room for a walk with no result
    task automatic drain();
        while (cmd_queue.size() != 0 || in_valid || due_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [PER_W-1:0] data);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge i_clk); while (!cfg_ready);
        case (idx)
            CFG_RELOAD:  reload_m = data;
            CFG_PREEMPT: preempt_m = data;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        // directed part under reset settings
        push_cmd(FUNC_TICK, 4'd0, 31'd0, 32'd0);
        push_cmd(FUNC_START, 4'd0, 31'd0, 32'h8000_0000);
        push_cmd(FUNC_START, 4'd15, 31'd1, 32'h7FFF_FFFF);
        push_cmd(FUNC_START, 4'd5, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        push_cmd(FUNC_START, 4'd3, 31'd3, 32'd0);
        push_cmd(FUNC_STOP, 4'd7, 31'd0, 32'd0);            // timer never started
        push_cmd(FUNC_NONE, 4'd10, 31'h5555_5555, 32'hAAAA_AAAA);
        push_cmd(FUNC_TICK, 4'd15, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        push_cmd(FUNC_STOP, 4'd5, 31'h2AAA_AAAA, 32'h5555_5555);
        push_cmd(FUNC_START, 4'd9, 31'd2, 32'h1234_5678);
        push_cmd(FUNC_START, 4'd9, 31'd4, 32'h0BAD_F00D);   // restart while running
        push_cmd(FUNC_START, 4'd12, 31'h2AAA_AAAA, 32'hA5A5_5A5A);
        push_cmd(FUNC_TICK, 4'd0, 31'd0, 32'd0);
        push_cmd(FUNC_TICK, 4'd0, 31'd0, 32'd0);
        push_cmd(FUNC_TICK, 4'd0, 31'd0, 32'd0);
        push_cmd(FUNC_TICK, 4'd0, 31'd0, 32'd0);
        push_cmd(FUNC_STOP, 4'd12, 31'd0, 32'd0);
        push_cmd(FUNC_TICK, 4'd0, 31'd0, 32'd0);
        drain();

        write_reg(CFG_RELOAD, 16'h0000);
        write_reg(CFG_PREEMPT, 16'h0001);
        queue_random(120);
        drain();

        send_idle_pct = 77;
        recv_idle_pct = 37;
        write_reg(CFG_RELOAD, 16'($urandom_range(1, 65534)));
        write_reg(CFG_PREEMPT, 16'($urandom_range(2, 9)));
        queue_random(120);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_RELOAD, 16'hFFFF);
        write_reg(CFG_PREEMPT, 16'hFFFF);
        queue_random(60);
        drain();
        write_reg(CFG_RELOAD, 16'h7FFF);
        write_reg(CFG_PREEMPT, 16'h0000);
        queue_random(60);
        drain();

        if (errors == 0 && due_words.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/stbt_pkg.sv
hdl/stbt_mod.sv
hdl/software_timer_bank_tick_top.sv
hdl/stbt_chk.sv
bench/tb_software_timer_bank_tick_top.sv
